[design/contiguous_block_allocator_assert.svh]
// Assertion macros shared by the allocator's checking code.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define CBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cba_pkg.sv]
// Shared types, widths and codes for the contiguous block allocator.
package cba_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int COUNT_W        = 7;
  localparam int COUNT_MAX      = 127;
  localparam int ADDR_W         = 7;
  localparam int START_W        = 6;
  localparam int STATUS_W       = 2;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;
  } map_req_t;

endpackage

[design/cba_map.sv]
// Free bitmap memory with per-block valid bits that read as free after reset.
module cba_map #(
  parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cba_pkg::map_req_t req,
  output logic              rd_free
);

  // Only blocks below the largest programmable count are ever touched.
  localparam int DEPTH = (NUM_BLOCKS < cba_pkg::COUNT_MAX) ? NUM_BLOCKS : cba_pkg::COUNT_MAX;
  localparam int AW    = $clog2(DEPTH);

  logic             mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [AW-1:0]    wa;
  logic [AW-1:0]    ra;

  assign wa = req.wr_addr[AW-1:0];
  assign ra = req.rd_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_free <= !valid[ra] || mem[ra];
    end
  end

endmodule

[design/cba_seq.sv]
// Request sequencer: bitmap scan, run counter and compare, run marking, result register.
module cba_seq #(
  parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cba_pkg::COUNT_W-1:0]   block_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [cba_pkg::COUNT_W-1:0]   run_length,
  input  logic [cba_pkg::START_W-1:0]   run_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cba_pkg::STATUS_W-1:0]  status,
  output logic [cba_pkg::START_W-1:0]   granted_start,
  output cba_pkg::map_req_t             map_req,
  input  logic                          rd_free
);

  localparam int CW  = cba_pkg::COUNT_W;
  localparam int CAP = (NUM_BLOCKS < cba_pkg::COUNT_MAX) ? NUM_BLOCKS : cba_pkg::COUNT_MAX;

  cba_pkg::state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 len_q;
  logic [CW-1:0]                 scan_idx;
  logic [CW-1:0]                 chk_idx;
  logic                          chk_pend;
  logic [CW-1:0]                 run;
  logic [CW-1:0]                 run_first;
  logic [CW-1:0]                 run_n;
  logic [CW-1:0]                 first_n;
  logic [CW-1:0]                 mark_idx;
  logic [CW-1:0]                 mark_left;
  logic                          mark_val;
  logic [cba_pkg::STATUS_W-1:0]  res_status;
  logic [cba_pkg::START_W-1:0]   res_granted;
  logic                          hit;
  logic                          scan_end;
  logic                          over;
  logic                          out_load;
  logic                          accept;

  assign count = (block_count > CW'(CAP)) ? CW'(CAP) : block_count;

  // A free must end at or below the active count.
  assign over = ({2'b00, run_start} + {1'b0, run_length}) > {1'b0, count};

  assign run_n    = run + 7'd1;
  assign first_n  = (run == '0) ? chk_idx : run_first;
  assign hit      = chk_pend && rd_free && (run_n == len_q);
  assign scan_end = !chk_pend && (scan_idx == count);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      cba_pkg::S_IDLE: begin
        if (in_valid) begin
          if (run_length == '0) begin
            state_next = cba_pkg::S_RESP;
          end else if (action == cba_pkg::ACT_ALLOC) begin
            state_next = cba_pkg::S_SCAN;
          end else if (over) begin
            state_next = cba_pkg::S_RESP;
          end else begin
            state_next = cba_pkg::S_MARK;
          end
        end
      end
      cba_pkg::S_SCAN: begin
        if (hit) begin
          state_next = cba_pkg::S_MARK;
        end else if (scan_end) begin
          state_next = cba_pkg::S_RESP;
        end
      end
      cba_pkg::S_MARK: begin
        if (mark_left == 7'd1) begin
          state_next = cba_pkg::S_RESP;
        end
      end
      cba_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = cba_pkg::S_IDLE;
        end
      end
      default: state_next = cba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_load        = 1'b0;
    map_req.rd_en   = 1'b0;
    map_req.rd_addr = scan_idx;
    map_req.wr_en   = 1'b0;
    map_req.wr_addr = mark_idx;
    map_req.wr_data = mark_val;
    case (state)
      cba_pkg::S_IDLE: in_ready = 1'b1;
      cba_pkg::S_SCAN: map_req.rd_en = (scan_idx != count);
      cba_pkg::S_MARK: map_req.wr_en = 1'b1;
      cba_pkg::S_RESP: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cba_pkg::S_IDLE;
      chk_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      chk_pend <= map_req.rd_en;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_idx;
    if (out_load) begin
      status        <= res_status;
      granted_start <= res_granted;
    end
    case (state)
      cba_pkg::S_IDLE: begin
        if (accept) begin
          len_q       <= run_length;
          scan_idx    <= '0;
          run         <= '0;
          mark_idx    <= {1'b0, run_start};
          mark_left   <= run_length;
          mark_val    <= 1'b1;
          res_granted <= '0;
          if (run_length == '0 || (action == cba_pkg::ACT_FREE && over)) begin
            res_status <= cba_pkg::ST_BAD;
          end else begin
            res_status <= cba_pkg::ST_DONE;
          end
        end
      end
      cba_pkg::S_SCAN: begin
        if (map_req.rd_en) begin
          scan_idx <= scan_idx + 7'd1;
        end
        if (chk_pend) begin
          if (rd_free) begin
            run_first <= first_n;
            run       <= run_n;
          end else begin
            run <= '0;
          end
        end
        if (hit) begin
          mark_idx    <= first_n;
          mark_left   <= len_q;
          mark_val    <= 1'b0;
          res_granted <= first_n[cba_pkg::START_W-1:0];
        end else if (scan_end) begin
          res_status <= cba_pkg::ST_NOROOM;
        end
      end
      cba_pkg::S_MARK: begin
        mark_idx  <= mark_idx + 7'd1;
        mark_left <= mark_left - 7'd1;
      end
      default: ;
    endcase
  end

endmodule

[design/contiguous_block_allocator.sv]
// Top level of the first-fit contiguous block allocator.
//
//   channel  signals                                    direction
//   in       in_valid/in_ready, action, run_length,     request in
//            run_start
//   out      out_valid/out_ready, status, granted_start result out
//   cfg      cfg_we, cfg_wdata (block_count)            write only
//
// From transfer in to a valid result: an allocate scans for a free run of its length L and
// marks it, one with no room scans up to the count, a free marks its L blocks and a bad
// request goes straight to the result; the bitmap is read or written one block per cycle.
// Transfers in are taken only in idle. Reset marks every block free at once. A result
// waiting at the output stalls only the finish of the next request, not its transfer in.
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cba_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [cba_pkg::COUNT_W-1:0]   run_length,
  input  logic [cba_pkg::START_W-1:0]   run_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cba_pkg::STATUS_W-1:0]  status,
  output logic [cba_pkg::START_W-1:0]   granted_start
);

`include "contiguous_block_allocator_assert.svh"

  logic [cba_pkg::COUNT_W-1:0] block_count;
  cba_pkg::map_req_t           map_req;
  logic                        rd_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= cba_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  cba_map #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_free (rd_free)
  );

  cba_seq #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .block_count   (block_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .run_length    (run_length),
    .run_start     (run_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_start (granted_start),
    .map_req       (map_req),
    .rd_free       (rd_free)
  );

  // A transfer in always leaves the sequencer busy in the following cycle.
  `CBA_ASSERT_NEXT(a_busy_after_accept, clk, rst,
                   in_valid && in_ready, !in_ready, "ready after accept")

  // The bitmap is only written while a request is in progress.
  `CBA_ASSERT_SAME(a_write_when_busy, clk, rst,
                   map_req.wr_en, !in_ready && !map_req.rd_en, "stray map write")

  // Only a successful allocate reports a start block.
  `CBA_ASSERT_SAME(a_grant_zero, clk, rst,
                   out_valid && status != cba_pkg::ST_DONE, granted_start == '0,
                   "nonzero start on failure")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the first-fit contiguous block allocator.
`timescale 1ns / 1ps

module testbench;

  localparam int NBLK = cba_pkg::NUM_BLOCKS_DEF;

  typedef struct packed {
    logic                        act;
    logic [cba_pkg::COUNT_W-1:0] len;
    logic [cba_pkg::START_W-1:0] start;
  } alloc_req_t;

  typedef struct packed {
    logic [cba_pkg::STATUS_W-1:0] status;
    logic [cba_pkg::START_W-1:0]  start;
  } alloc_reply_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [cba_pkg::COUNT_W-1:0]  cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         action = cba_pkg::ACT_ALLOC;
  logic [cba_pkg::COUNT_W-1:0]  run_length = '0;
  logic [cba_pkg::START_W-1:0]  run_start = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [cba_pkg::STATUS_W-1:0] status;
  logic [cba_pkg::START_W-1:0]  granted_start;

  alloc_req_t   pending_reqs[$];
  alloc_reply_t awaited_replies[$];

  // Predicted allocator state: one bit per block, 1 means free.
  logic [NBLK-1:0]             map_free;
  logic [cba_pkg::COUNT_W-1:0] model_count;

  int errors = 0;
  int gen_count = cba_pkg::COUNT_RESET;
  int send_gap, send_calm, recv_gap, recv_calm, hold_left, taken;

  contiguous_block_allocator #(.NUM_BLOCKS(NBLK)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .run_length(run_length), .run_start(run_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_start(granted_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int idle_cycles(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void predict_request(input alloc_req_t q, output alloc_reply_t r);
    int  eff, run, first;
    bit  found;
    eff = (model_count > NBLK) ? NBLK : int'(model_count);
    r.status = cba_pkg::ST_DONE;
    r.start = '0;
    found = 1'b0;
    run = 0;
    first = 0;
    if (q.len == 0) begin
      r.status = cba_pkg::ST_BAD;
    end else if (q.act == cba_pkg::ACT_ALLOC) begin
      for (int i = 0; i < eff && !found; i++) begin
        if (map_free[i]) begin
          if (run == 0) first = i;
          run++;
          if (run == int'(q.len)) found = 1'b1;
        end else begin
          run = 0;
        end
      end
      if (found) begin
        for (int i = first; i < first + int'(q.len); i++) map_free[i] = 1'b0;
        r.start = cba_pkg::START_W'(first);
      end else begin
        r.status = cba_pkg::ST_NOROOM;
      end
    end else if (int'(q.start) + int'(q.len) > eff) begin
      r.status = cba_pkg::ST_BAD;
    end else begin
      for (int i = int'(q.start); i < int'(q.start) + int'(q.len); i++) map_free[i] = 1'b1;
    end
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Driver: offers queued requests and predicts each one as its transfer happens.
  always @(posedge clk) begin
    alloc_req_t   req;
    alloc_reply_t reply;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
      map_free = '1;
      model_count = cba_pkg::COUNT_RESET;
    end else begin
      if (cfg_we) model_count = cfg_wdata;
      if (in_valid && in_ready) begin
        req.act = action;
        req.len = run_length;
        req.start = run_start;
        predict_request(req, reply);
        awaited_replies.push_back(reply);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          action <= req.act;
          run_length <= req.len;
          run_start <= req.start;
          send_gap = idle_cycles(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, including two long hold-offs that back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      recv_calm = 0;
      hold_left = 0;
      taken = 0;
    end else begin
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 400 || taken == 1200) hold_left = 300;
        else recv_gap = idle_cycles(recv_calm);
      end else if (recv_gap == 0 && hold_left == 0 && $urandom_range(0, 15) == 0) begin
        recv_gap = idle_cycles(recv_calm);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch("unexpected result, status", -1, status);
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.status) flag_mismatch("status", want.status, status);
        if (granted_start !== want.start)
          flag_mismatch("granted_start", want.start, granted_start);
      end
    end
  end

  task automatic add_req(input logic act, input int len, input int start);
    alloc_req_t q;
    q.act = act;
    q.len = cba_pkg::COUNT_W'(len);
    q.start = cba_pkg::START_W'(start);
    pending_reqs.push_back(q);
  endtask

  // Mostly plausible allocate and free traffic for the current count, some noise.
  task automatic add_random(input int n);
    int eff, r, len, start;
    eff = (gen_count > NBLK) ? NBLK : gen_count;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      start = $urandom_range(0, NBLK - 1);
      if (r < 48) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(1, (eff > 0) ? eff : 1);
        else len = $urandom_range(0, cba_pkg::COUNT_MAX);
        add_req(cba_pkg::ACT_ALLOC, len, start);
      end else if (r < 92) begin
        if (eff == 0) begin
          len = $urandom_range(1, 4);
        end else begin
          start = $urandom_range(0, eff - 1);
          if ($urandom_range(0, 9) == 0) len = $urandom_range(1, eff);
          else len = $urandom_range(1, (eff - start < 8) ? eff - start : 8);
        end
        add_req(cba_pkg::ACT_FREE, len, start);
      end else begin
        add_req(1'($urandom_range(0, 1)), $urandom_range(0, cba_pkg::COUNT_MAX), start);
      end
    end
  endtask

  // Sampled at the falling edge, where the driver's updates have all settled.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || awaited_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(input int value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cba_pkg::COUNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    gen_count = value;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero lengths, whole-map grant, long requests, out-of-range and double frees.
    add_req(cba_pkg::ACT_ALLOC, 0, 0);
    add_req(cba_pkg::ACT_FREE, 0, 5);
    add_req(cba_pkg::ACT_ALLOC, 64, 63);
    add_req(cba_pkg::ACT_ALLOC, 1, 0);
    add_req(cba_pkg::ACT_FREE, 64, 0);
    add_req(cba_pkg::ACT_ALLOC, 65, 0);
    add_req(cba_pkg::ACT_ALLOC, 127, 0);
    add_req(cba_pkg::ACT_FREE, 1, 63);
    add_req(cba_pkg::ACT_FREE, 2, 63);
    add_req(cba_pkg::ACT_FREE, 127, 0);
    // First fit should reuse the hole left by the freed middle run.
    add_req(cba_pkg::ACT_ALLOC, 3, 0);
    add_req(cba_pkg::ACT_ALLOC, 5, 0);
    add_req(cba_pkg::ACT_ALLOC, 2, 0);
    add_req(cba_pkg::ACT_FREE, 5, 3);
    add_req(cba_pkg::ACT_ALLOC, 4, 0);
    add_req(cba_pkg::ACT_ALLOC, 56, 0);
    add_req(cba_pkg::ACT_FREE, 2, 62);
    add_req(cba_pkg::ACT_ALLOC, 2, 0);
    add_req(cba_pkg::ACT_FREE, 64, 0);
    add_random(250);

    set_count(0);
    add_req(cba_pkg::ACT_ALLOC, 1, 0);
    add_req(cba_pkg::ACT_FREE, 1, 0);
    add_random(40);

    set_count(127);
    add_req(cba_pkg::ACT_FREE, 64, 0);
    add_req(cba_pkg::ACT_ALLOC, 64, 0);
    add_random(250);

    set_count(1);
    add_random(60);

    set_count(2);
    add_random(80);

    set_count(64);
    add_req(cba_pkg::ACT_FREE, 64, 0);
    add_req(cba_pkg::ACT_ALLOC, 64, 0);
    add_random(2);

    // Blocks above a lowered count keep their state but are out of reach.
    set_count(8);
    add_req(cba_pkg::ACT_FREE, 64, 0);
    add_req(cba_pkg::ACT_ALLOC, 64, 0);
    add_req(cba_pkg::ACT_FREE, 1, 8);
    add_req(cba_pkg::ACT_FREE, 8, 0);
    add_req(cba_pkg::ACT_ALLOC, 9, 0);
    add_random(100);

    set_count(64);
    add_random(300);

    set_count(17);
    add_random(200);

    set_count(100);
    add_random(200);

    set_count($urandom_range(3, 63));
    add_random(150);

    set_count(64);
    add_random(170);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/cba_pkg.sv
design/cba_map.sv
design/cba_seq.sv
design/contiguous_block_allocator.sv
bench/testbench.sv
